// ===== sv/ptq_pkg.sv =====
// Package for the priority task queue: codes, field widths, controller/datapath
// command and status structs. No dependencies.
package ptq_pkg;

  localparam int RING_DEPTH_DEF = 64;
  localparam int ID_BITS_DEF    = 16;

  localparam int CMD_W    = 2;
  localparam int ID_W     = 16;
  localparam int PRIO_W   = 2;
  localparam int HANDLE_W = 32;
  localparam int STATUS_W = 2;
  localparam int DEPTH_W  = 7;

  localparam logic [PRIO_W-1:0] PRIO_MAX = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_SUBMIT  = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_CANCEL  = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SUB,
    S_DEQ,
    S_CAN,
    S_RESULT
  } state_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_TAIL,
    PTR_HEAD,
    PTR_PREV,
    PTR_NEXT
  } ptr_op_t;

  typedef enum logic [1:0] {
    WR_NEW,
    WR_RD,
    WR_CANCEL
  } wr_sel_t;

  typedef struct packed {
    logic    load_in;
    ptr_op_t ptr_op;
    logic    rd_prev;
    logic    mem_we;
    wr_sel_t wr_sel;
    logic    sub_start;
    logic    deq_cap;
    logic    deq_pop;
    logic    set_status;
    status_t status_val;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_e_t cmd;
    logic   full;
    logic   empty;
    logic   prio_gt;
    logic   at_head;
    logic   id_match;
    logic   last;
  } dp_stat_t;

endpackage

// ===== sv/ptq_in_if.sv =====
// Command channel of the priority task queue: valid/ready plus one command word.
// Depends on ptq_pkg.
interface ptq_in_if;
  logic                          valid;
  logic                          ready;
  logic [ptq_pkg::CMD_W-1:0]     cmd;
  logic [ptq_pkg::ID_W-1:0]      task_id;
  logic [ptq_pkg::PRIO_W-1:0]    priority_req;
  logic [ptq_pkg::HANDLE_W-1:0]  task_handle;

  modport source (output valid, cmd, task_id, priority_req, task_handle, input ready);
  modport sink (input valid, cmd, task_id, priority_req, task_handle, output ready);
endinterface

// ===== sv/ptq_out_if.sv =====
// Result channel of the priority task queue: valid/ready plus one result word.
// Depends on ptq_pkg.
interface ptq_out_if;
  logic                          valid;
  logic                          ready;
  logic [ptq_pkg::STATUS_W-1:0]  status;
  logic [ptq_pkg::ID_W-1:0]      out_task_id;
  logic [ptq_pkg::PRIO_W-1:0]    out_priority;
  logic [ptq_pkg::HANDLE_W-1:0]  out_handle;
  logic                          was_cancelled;
  logic [ptq_pkg::DEPTH_W-1:0]   depth_after;

  modport source (output valid, status, out_task_id, out_priority, out_handle, was_cancelled,
                  depth_after, input ready);
  modport sink (input valid, status, out_task_id, out_priority, out_handle, was_cancelled,
                depth_after, output ready);
endinterface

// ===== sv/ptq_ctrl.sv =====
// Controller of the priority task queue: sequences submit, dequeue and cancel
// over the datapath. Depends on ptq_pkg.
module ptq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ptq_pkg::dp_stat_t stat,
  output ptq_pkg::ctrl_cmd_t cmd
);

  ptq_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ptq_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptq_pkg::S_IDLE: begin
        if (in_valid) state_nxt = ptq_pkg::S_EXEC;
      end
      ptq_pkg::S_EXEC: begin
        unique case (stat.cmd)
          ptq_pkg::CMD_SUBMIT:  state_nxt = stat.full  ? ptq_pkg::S_RESULT : ptq_pkg::S_SUB;
          ptq_pkg::CMD_DEQUEUE: state_nxt = stat.empty ? ptq_pkg::S_RESULT : ptq_pkg::S_DEQ;
          ptq_pkg::CMD_CANCEL:  state_nxt = stat.empty ? ptq_pkg::S_RESULT : ptq_pkg::S_CAN;
          default:              state_nxt = ptq_pkg::S_RESULT;
        endcase
      end
      ptq_pkg::S_SUB: begin
        if (stat.at_head || !stat.prio_gt) state_nxt = ptq_pkg::S_RESULT;
      end
      ptq_pkg::S_DEQ: state_nxt = ptq_pkg::S_RESULT;
      ptq_pkg::S_CAN: begin
        if (stat.id_match || stat.last) state_nxt = ptq_pkg::S_RESULT;
      end
      ptq_pkg::S_RESULT: begin
        if (out_free) state_nxt = ptq_pkg::S_IDLE;
      end
      default: state_nxt = ptq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.ptr_op     = ptq_pkg::PTR_HOLD;
    cmd.wr_sel     = ptq_pkg::WR_NEW;
    cmd.status_val = ptq_pkg::ST_OK;
    unique case (state_r)
      ptq_pkg::S_IDLE: cmd.load_in = in_valid;
      ptq_pkg::S_EXEC: begin
        unique case (stat.cmd)
          ptq_pkg::CMD_SUBMIT: begin
            if (stat.full) begin
              cmd.set_status = 1'b1;
              cmd.status_val = ptq_pkg::ST_FULL;
            end else begin
              cmd.ptr_op    = ptq_pkg::PTR_TAIL;
              cmd.rd_prev   = 1'b1;
              cmd.sub_start = 1'b1;
            end
          end
          ptq_pkg::CMD_DEQUEUE: begin
            if (stat.empty) begin
              cmd.set_status = 1'b1;
              cmd.status_val = ptq_pkg::ST_EMPTY;
            end else begin
              cmd.ptr_op = ptq_pkg::PTR_HEAD;
            end
          end
          ptq_pkg::CMD_CANCEL: begin
            if (stat.empty) begin
              cmd.set_status = 1'b1;
              cmd.status_val = ptq_pkg::ST_NOT_FOUND;
            end else begin
              cmd.ptr_op = ptq_pkg::PTR_HEAD;
            end
          end
          default: ;
        endcase
      end
      ptq_pkg::S_SUB: begin
        cmd.mem_we = 1'b1;
        if (stat.at_head || !stat.prio_gt) begin
          cmd.wr_sel = ptq_pkg::WR_NEW;
        end else begin
          cmd.wr_sel  = ptq_pkg::WR_RD;
          cmd.ptr_op  = ptq_pkg::PTR_PREV;
          cmd.rd_prev = 1'b1;
        end
      end
      ptq_pkg::S_DEQ: begin
        cmd.deq_cap = 1'b1;
        cmd.deq_pop = 1'b1;
      end
      ptq_pkg::S_CAN: begin
        if (stat.id_match) begin
          cmd.mem_we = 1'b1;
          cmd.wr_sel = ptq_pkg::WR_CANCEL;
        end else if (stat.last) begin
          cmd.set_status = 1'b1;
          cmd.status_val = ptq_pkg::ST_NOT_FOUND;
        end else begin
          cmd.ptr_op = ptq_pkg::PTR_NEXT;
        end
      end
      ptq_pkg::S_RESULT: cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/ptq_dp.sv =====
// Datapath of the priority task queue: entry ring memory, head/tail/count,
// walk pointer, working and output registers. Depends on ptq_pkg.
module ptq_dp #(
  parameter int RING_DEPTH = ptq_pkg::RING_DEPTH_DEF,
  parameter int ID_BITS    = ptq_pkg::ID_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ptq_pkg::ctrl_cmd_t              cmd,
  output ptq_pkg::dp_stat_t               stat,
  input  logic [ptq_pkg::CMD_W-1:0]       in_cmd,
  input  logic [ptq_pkg::ID_W-1:0]        in_task_id,
  input  logic [ptq_pkg::PRIO_W-1:0]      in_priority_req,
  input  logic [ptq_pkg::HANDLE_W-1:0]    in_task_handle,
  output logic [ptq_pkg::STATUS_W-1:0]    out_status,
  output logic [ptq_pkg::ID_W-1:0]        out_task_id,
  output logic [ptq_pkg::PRIO_W-1:0]      out_priority,
  output logic [ptq_pkg::HANDLE_W-1:0]    out_handle,
  output logic                            out_was_cancelled,
  output logic [ptq_pkg::DEPTH_W-1:0]     out_depth_after
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);

  typedef struct packed {
    logic [ID_BITS-1:0]           id;
    logic [ptq_pkg::PRIO_W-1:0]   prio;
    logic [ptq_pkg::HANDLE_W-1:0] handle;
    logic                         canc;
  } entry_t;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    ring_next = (i == AW'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
    ring_prev = (i == '0) ? AW'(RING_DEPTH - 1) : i - 1'b1;
  endfunction

  entry_t entry_mem [RING_DEPTH];
  entry_t rd_data_r;
  entry_t new_r;
  entry_t wr_data;

  ptq_pkg::cmd_e_t  cmd_r;
  ptq_pkg::status_t status_r;

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] rd_addr;

  logic [ID_BITS-1:0]           res_id_r;
  logic [ptq_pkg::PRIO_W-1:0]   res_prio_r;
  logic [ptq_pkg::HANDLE_W-1:0] res_handle_r;
  logic                         res_canc_r;

  logic [ptq_pkg::STATUS_W-1:0] out_status_r;
  logic [ptq_pkg::ID_W-1:0]     out_id_r;
  logic [ptq_pkg::PRIO_W-1:0]   out_prio_r;
  logic [ptq_pkg::HANDLE_W-1:0] out_handle_r;
  logic                         out_canc_r;
  logic [ptq_pkg::DEPTH_W-1:0]  out_depth_r;

  always_comb begin
    unique case (cmd.ptr_op)
      ptq_pkg::PTR_HOLD: ptr_nxt = ptr_r;
      ptq_pkg::PTR_TAIL: ptr_nxt = tail_r;
      ptq_pkg::PTR_HEAD: ptr_nxt = head_r;
      ptq_pkg::PTR_PREV: ptr_nxt = ring_prev(ptr_r);
      ptq_pkg::PTR_NEXT: ptr_nxt = ring_next(ptr_r);
      default:           ptr_nxt = ptr_r;
    endcase
  end

  assign rd_addr = cmd.rd_prev ? ring_prev(ptr_nxt) : ptr_nxt;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (cmd.sub_start) begin
      tail_nxt  = ring_next(tail_r);
      count_nxt = count_r + 1'b1;
    end
    if (cmd.deq_pop) begin
      head_nxt  = ring_next(head_r);
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    wr_data = new_r;
    unique case (cmd.wr_sel)
      ptq_pkg::WR_NEW:    wr_data = new_r;
      ptq_pkg::WR_RD:     wr_data = rd_data_r;
      ptq_pkg::WR_CANCEL: begin
        wr_data      = rd_data_r;
        wr_data.canc = 1'b1;
      end
      default:            wr_data = new_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) entry_mem[ptr_r] <= wr_data;
    rd_data_r <= entry_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      ptr_r   <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  // working registers: command word, new entry, status and dequeued fields
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r       <= ptq_pkg::cmd_e_t'(in_cmd);
      new_r.id    <= ID_BITS'(in_task_id);
      new_r.prio  <= (in_priority_req > ptq_pkg::PRIO_MAX) ? ptq_pkg::PRIO_MAX
                                                            : in_priority_req;
      new_r.handle <= in_task_handle;
      new_r.canc  <= 1'b0;
      status_r    <= ptq_pkg::ST_OK;
      res_id_r    <= '0;
      res_prio_r  <= '0;
      res_handle_r <= '0;
      res_canc_r  <= 1'b0;
    end else begin
      if (cmd.set_status) status_r <= cmd.status_val;
      if (cmd.deq_cap) begin
        res_id_r     <= rd_data_r.id;
        res_prio_r   <= rd_data_r.prio;
        res_handle_r <= rd_data_r.handle;
        res_canc_r   <= rd_data_r.canc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_id_r     <= ptq_pkg::ID_W'(res_id_r);
      out_prio_r   <= res_prio_r;
      out_handle_r <= res_handle_r;
      out_canc_r   <= res_canc_r;
      out_depth_r  <= ptq_pkg::DEPTH_W'(count_r);
    end
  end

  assign stat.cmd      = cmd_r;
  assign stat.full     = (count_r == CW'(RING_DEPTH));
  assign stat.empty    = (count_r == '0);
  assign stat.prio_gt  = (new_r.prio > rd_data_r.prio);
  assign stat.at_head  = (ptr_r == head_r);
  assign stat.id_match = (rd_data_r.id == new_r.id) && !rd_data_r.canc;
  assign stat.last     = (ring_next(ptr_r) == tail_r);

  assign out_status        = out_status_r;
  assign out_task_id       = out_id_r;
  assign out_priority      = out_prio_r;
  assign out_handle        = out_handle_r;
  assign out_was_cancelled = out_canc_r;
  assign out_depth_after   = out_depth_r;

endmodule

// ===== sv/priority_task_queue_with_cancel_unit.sv =====
// Priority task queue with cancel marks: top level joining controller and datapath.
// Depends on ptq_pkg, ptq_in_if, ptq_out_if, ptq_ctrl, ptq_dp.
//
// Usage: in_ch carries one command word (submit, dequeue, cancel by id, or no-op);
// out_ch returns exactly one result word per command, in order. Entries live in a
// ring memory of RING_DEPTH words; a submit is bubbled toward the head one entry
// per cycle while its priority is strictly above its neighbour's, and a cancel
// scans from the head one entry per cycle, both through the one memory's read and write ports.
// A command is taken in IDLE and decoded in EXEC; a submit then bubbles in SUB, a
// dequeue pops in DEQ and a cancel scans in CAN, while a full or empty queue and a
// no-op go straight to RESULT, which loads the output register. One command is in work
// at a time; in_ch.ready rises again in the cycle the result word appears.
// The result sits in an output register, so the next command is taken while the
// previous word waits; a stalled out_ch holds the block only when a second
// result is ready. Reset (rst_n low, synchronous) empties the queue; no memory
// clearing is needed.
module priority_task_queue_with_cancel_unit #(
  parameter int RING_DEPTH = ptq_pkg::RING_DEPTH_DEF,
  parameter int ID_BITS    = ptq_pkg::ID_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  ptq_in_if.sink         in_ch,
  ptq_out_if.source      out_ch
);

  ptq_pkg::ctrl_cmd_t ctrl_cmd;
  ptq_pkg::dp_stat_t  dp_stat;

  ptq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (dp_stat),
    .cmd       (ctrl_cmd)
  );

  ptq_dp #(
    .RING_DEPTH (RING_DEPTH),
    .ID_BITS    (ID_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (ctrl_cmd),
    .stat              (dp_stat),
    .in_cmd            (in_ch.cmd),
    .in_task_id        (in_ch.task_id),
    .in_priority_req   (in_ch.priority_req),
    .in_task_handle    (in_ch.task_handle),
    .out_status        (out_ch.status),
    .out_task_id       (out_ch.out_task_id),
    .out_priority      (out_ch.out_priority),
    .out_handle        (out_ch.out_handle),
    .out_was_cancelled (out_ch.was_cancelled),
    .out_depth_after   (out_ch.depth_after)
  );

  a_full_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ptq_pkg::ST_FULL)
      |-> out_ch.depth_after == ptq_pkg::DEPTH_W'(RING_DEPTH))
    else $error("full status with depth below capacity");

  a_empty_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ptq_pkg::ST_EMPTY) |-> out_ch.depth_after == '0)
    else $error("empty status with entries queued");

  a_fail_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ptq_pkg::ST_OK)
      |-> (out_ch.out_handle == '0 && out_ch.out_task_id == '0 && !out_ch.was_cancelled))
    else $error("entry fields set on failed command");

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second command taken while one is in work");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for priority_task_queue_with_cancel_unit: directed and random
// submit/dequeue/cancel traffic against a behavioural ring model, with idling phases.
// Depends on ptq_pkg, ptq_in_if, ptq_out_if and the unit itself.
module tb_top;

  localparam int RING_SIZE      = ptq_pkg::RING_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_CMDS    = 1050;

  typedef struct packed {
    ptq_pkg::cmd_e_t                cmd;
    logic [ptq_pkg::ID_W-1:0]       id;
    logic [ptq_pkg::PRIO_W-1:0]     prio;
    logic [ptq_pkg::HANDLE_W-1:0]   handle;
  } queue_cmd_t;

  typedef struct packed {
    ptq_pkg::status_t               status;
    logic [ptq_pkg::ID_W-1:0]       id;
    logic [ptq_pkg::PRIO_W-1:0]     prio;
    logic [ptq_pkg::HANDLE_W-1:0]   handle;
    logic                           cancelled;
    logic [ptq_pkg::DEPTH_W-1:0]    depth;
  } queue_result_t;

  typedef struct packed {
    logic [ptq_pkg::ID_W-1:0]       id;
    logic [ptq_pkg::PRIO_W-1:0]     prio;
    logic [ptq_pkg::HANDLE_W-1:0]   handle;
    logic                           cancelled;
  } task_entry_t;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_t;

  logic clk;
  logic rst_n;

  ptq_in_if  in_ch ();
  ptq_out_if out_ch ();

  priority_task_queue_with_cancel_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // shadow ring
  task_entry_t ring [RING_SIZE];
  int          ring_head;
  int          ring_tail;
  int          ring_count;

  queue_cmd_t    pending_cmds [$];
  queue_result_t expected_words [$];
  logic [ptq_pkg::ID_W-1:0] recent_ids [$];
  queue_cmd_t    held_cmd;
  bit            holding;

  int accepted_cmds;
  int checked_words;
  int mismatch_count;
  int stall_cycles;
  int full_count, empty_count, not_found_count, skipped_count, peak_depth;

  function automatic queue_result_t apply_queue_cmd(queue_cmd_t c);
    queue_result_t r;
    task_entry_t   tmp;
    int            pos, prv, n, idx;
    bit            found;
    r = '0;
    r.status = ptq_pkg::ST_OK;
    case (c.cmd)
      ptq_pkg::CMD_SUBMIT: begin
        if (ring_count >= RING_SIZE) begin
          r.status = ptq_pkg::ST_FULL;
        end else begin
          pos = ring_tail;
          ring[pos].id        = c.id;
          ring[pos].prio      = (c.prio > ptq_pkg::PRIO_MAX) ? ptq_pkg::PRIO_MAX : c.prio;
          ring[pos].handle    = c.handle;
          ring[pos].cancelled = 1'b0;
          ring_tail  = (pos + 1) % RING_SIZE;
          ring_count++;
          prv = (pos + RING_SIZE - 1) % RING_SIZE;
          n = 1;
          // bubble toward head on strictly higher priority only
          while (n < ring_count && ring[pos].prio > ring[prv].prio) begin
            tmp       = ring[pos];
            ring[pos] = ring[prv];
            ring[prv] = tmp;
            pos = prv;
            prv = (prv + RING_SIZE - 1) % RING_SIZE;
            n++;
          end
        end
      end
      ptq_pkg::CMD_DEQUEUE: begin
        if (ring_count == 0) begin
          r.status = ptq_pkg::ST_EMPTY;
        end else begin
          r.id        = ring[ring_head].id;
          r.prio      = ring[ring_head].prio;
          r.handle    = ring[ring_head].handle;
          r.cancelled = ring[ring_head].cancelled;
          ring_head = (ring_head + 1) % RING_SIZE;
          ring_count--;
        end
      end
      ptq_pkg::CMD_CANCEL: begin
        found = 1'b0;
        idx = ring_head;
        for (n = 0; n < ring_count && !found; n++) begin
          if (ring[idx].id == c.id && !ring[idx].cancelled) begin
            ring[idx].cancelled = 1'b1;
            found = 1'b1;
          end
          idx = (idx + 1) % RING_SIZE;
        end
        if (!found) r.status = ptq_pkg::ST_NOT_FOUND;
      end
      default: ;
    endcase
    r.depth = ring_count[ptq_pkg::DEPTH_W-1:0];
    return r;
  endfunction

  function automatic queue_cmd_t cmd_word(ptq_pkg::cmd_e_t cmd,
                                          logic [ptq_pkg::ID_W-1:0] id,
                                          logic [ptq_pkg::PRIO_W-1:0] prio,
                                          logic [ptq_pkg::HANDLE_W-1:0] handle);
    queue_cmd_t c;
    c.cmd    = cmd;
    c.id     = id;
    c.prio   = prio;
    c.handle = handle;
    return c;
  endfunction

  function automatic queue_cmd_t random_cmd(traffic_mix_t mix);
    queue_cmd_t c;
    int sub_w, deq_w, can_w, roll;
    case (mix)
      MIX_FILL:  begin sub_w = 80; deq_w = 5;  can_w = 12; end
      MIX_DRAIN: begin sub_w = 8;  deq_w = 80; can_w = 10; end
      default:   begin sub_w = 40; deq_w = 35; can_w = 22; end
    endcase
    roll = $urandom_range(99);
    c.id     = ($urandom_range(1) == 0) ? ptq_pkg::ID_W'($urandom_range(15))
                                        : ptq_pkg::ID_W'($urandom);
    c.prio   = ptq_pkg::PRIO_W'($urandom_range(3));
    c.handle = $urandom;
    if (roll < sub_w) begin
      c.cmd = ptq_pkg::CMD_SUBMIT;
      recent_ids.push_back(c.id);
      if (recent_ids.size() > 48) void'(recent_ids.pop_front());
    end else if (roll < sub_w + deq_w) begin
      c.cmd = ptq_pkg::CMD_DEQUEUE;
    end else if (roll < sub_w + deq_w + can_w) begin
      c.cmd = ptq_pkg::CMD_CANCEL;
      if (recent_ids.size() > 0 && $urandom_range(3) != 0)
        c.id = recent_ids[$urandom_range(recent_ids.size() - 1)];
    end else begin
      c.cmd = ptq_pkg::CMD_NOP;
    end
    return c;
  endfunction

  // 0: no idling, 1: sender idle, 2: receiver stall, 3: both light
  function automatic int idle_phase();
    return (accepted_cmds / 130) % 4;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : drive_cmds
    int idle_pct;
    idle_pct = (idle_phase() == 1) ? 74 : (idle_phase() == 3) ? 14 : 0;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_words.push_back(apply_queue_cmd(held_cmd));
        accepted_cmds++;
        holding = 1'b0;
      end
      if (!holding && pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
        held_cmd = pending_cmds.pop_front();
        holding  = 1'b1;
        in_ch.cmd          <= held_cmd.cmd;
        in_ch.task_id      <= held_cmd.id;
        in_ch.priority_req <= held_cmd.prio;
        in_ch.task_handle  <= held_cmd.handle;
      end
      in_ch.valid <= holding;
    end
  end

  always @(posedge clk) begin : check_words
    queue_result_t got, want;
    int stall_pct;
    stall_pct = (idle_phase() == 2) ? 74 : (idle_phase() == 3) ? 14 : 0;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.status    = ptq_pkg::status_t'(out_ch.status);
        got.id        = out_ch.out_task_id;
        got.prio      = out_ch.out_priority;
        got.handle    = out_ch.out_handle;
        got.cancelled = out_ch.was_cancelled;
        got.depth     = out_ch.depth_after;
        if (expected_words.size() == 0) begin
          $display("%0t ns: unexpected result word, expected none, got 0x%0h", $time, got);
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("out_task_id", 32'(want.id), 32'(got.id));
          check_field("out_priority", 32'(want.prio), 32'(got.prio));
          check_field("out_handle", want.handle, got.handle);
          check_field("was_cancelled", 32'(want.cancelled), 32'(got.cancelled));
          check_field("depth_after", 32'(want.depth), 32'(got.depth));
          checked_words++;
          if (want.status == ptq_pkg::ST_FULL) full_count++;
          if (want.status == ptq_pkg::ST_EMPTY) empty_count++;
          if (want.status == ptq_pkg::ST_NOT_FOUND) not_found_count++;
          if (want.cancelled) skipped_count++;
          if (int'(want.depth) > peak_depth) peak_depth = int'(want.depth);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin : run_test
    bit           timed_out;
    int           remaining, len;
    traffic_mix_t mix;
    rst_n              = 1'b0;
    holding            = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = ptq_pkg::CMD_NOP;
    in_ch.task_id      = '0;
    in_ch.priority_req = '0;
    in_ch.task_handle  = '0;
    out_ch.ready       = 1'b0;
    ring_head = 0;
    ring_tail = 0;
    ring_count = 0;
    foreach (ring[i]) ring[i] = '0;

    // empty-queue cases, then ordering, saturation, cancel marks
    pending_cmds.push_back(cmd_word(ptq_pkg::CMD_DEQUEUE, 16'h0000, 2'd0, 32'h0000_0000));
    pending_cmds.push_back(cmd_word(ptq_pkg::CMD_CANCEL,  16'h0005, 2'd0, 32'h0000_0000));
    pending_cmds.push_back(cmd_word(ptq_pkg::CMD_NOP,     16'h0000, 2'd0, 32'h0000_0000));
    pending_cmds.push_back(cmd_word(ptq_pkg::CMD_SUBMIT,  16'h0000, 2'd0, 32'h0000_0000));
    pending_cmds.push_back(cmd_word(ptq_pkg::CMD_SUBMIT,  16'hFFFF, 2'd3, 32'hFFFF_FFFF));
    pending_cmds.push_back(cmd_word(ptq_pkg::CMD_SUBMIT,  16'h0005, 2'd1, 32'hA5A5_A5A5));
    pending_cmds.push_back(cmd_word(ptq_pkg::CMD_SUBMIT,  16'h0005, 2'd1, 32'h5A5A_5A5A));
    pending_cmds.push_back(cmd_word(ptq_pkg::CMD_SUBMIT,  16'h0007, 2'd2, 32'h1234_5678));
    pending_cmds.push_back(cmd_word(ptq_pkg::CMD_CANCEL,  16'h0005, 2'd0, 32'h0000_0000));
    pending_cmds.push_back(cmd_word(ptq_pkg::CMD_CANCEL,  16'h0005, 2'd3, 32'hFFFF_FFFF));
    pending_cmds.push_back(cmd_word(ptq_pkg::CMD_CANCEL,  16'h0005, 2'd0, 32'h0000_0000));
    pending_cmds.push_back(cmd_word(ptq_pkg::CMD_CANCEL,  16'hFFFF, 2'd0, 32'h0000_0000));
    pending_cmds.push_back(cmd_word(ptq_pkg::CMD_NOP,     16'hFFFF, 2'd3, 32'hFFFF_FFFF));
    repeat (6)
      pending_cmds.push_back(cmd_word(ptq_pkg::CMD_DEQUEUE, 16'hFFFF, 2'd3, 32'hFFFF_FFFF));
    pending_cmds.push_back(cmd_word(ptq_pkg::CMD_SUBMIT,  16'h0001, 2'd0, 32'hDEAD_BEEF));
    pending_cmds.push_back(cmd_word(ptq_pkg::CMD_SUBMIT,  16'h0002, 2'd2, 32'h0BAD_F00D));
    pending_cmds.push_back(cmd_word(ptq_pkg::CMD_CANCEL,  16'h0001, 2'd0, 32'h0000_0000));
    pending_cmds.push_back(cmd_word(ptq_pkg::CMD_DEQUEUE, 16'h0000, 2'd0, 32'h0000_0000));
    pending_cmds.push_back(cmd_word(ptq_pkg::CMD_DEQUEUE, 16'h0000, 2'd0, 32'h0000_0000));

    // open with a fill burst so the full case is reached early
    repeat (100) pending_cmds.push_back(random_cmd(MIX_FILL));
    remaining = RANDOM_CMDS - 100;
    while (remaining > 0) begin
      mix = traffic_mix_t'($urandom_range(2));
      len = $urandom_range(30, 110);
      if (len > remaining) len = remaining;
      repeat (len) pending_cmds.push_back(random_cmd(mix));
      remaining -= len;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    timed_out = 1'b0;
    while (!timed_out &&
           !(pending_cmds.size() == 0 && !holding && expected_words.size() == 0)) begin
      @(negedge clk);
      timed_out = (stall_cycles >= WATCHDOG_LIMIT);
    end

    if (timed_out)
      $display("%0t ns: no handshake for %0d cycles, %0d result words outstanding",
               $time, WATCHDOG_LIMIT, expected_words.size());
    else
      repeat (RING_SIZE + 16) @(posedge clk);

    $display("Covered %0d commands and %0d checked words, %0d mismatches.",
             accepted_cmds, checked_words, mismatch_count);
    $display("Full %0d, empty %0d, id not found %0d, cancelled words %0d, peak depth %0d.",
             full_count, empty_count, not_found_count, skipped_count, peak_depth);
    if (!timed_out && mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ptq_pkg.sv
sv/ptq_in_if.sv
sv/ptq_out_if.sv
sv/ptq_ctrl.sv
sv/ptq_dp.sv
sv/priority_task_queue_with_cancel_unit.sv
bench/tb_top.sv
